// ----- hdl/gdi_pkg.sv -----
// ----------------------------------------------------------------------------
// gdi_pkg
// Shared sizes, codes and record types of the iFUB graph diameter block.
// ----------------------------------------------------------------------------
`default_nettype none

package gdi_pkg;

  // Graph store sizes.
  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 4096;
  localparam int ENTRIES   = 2 * MAX_EDGES;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;
  localparam int ENT_W     = $clog2(ENTRIES);
  localparam int ECNT_W    = ENT_W + 1;
  localparam int UB_W      = NODE_W + 2;

  // Input command codes.
  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_ADD     = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_DROPPED = 2'd1;
  localparam logic [1:0] STATUS_BADROOT = 2'd2;

  // Per-node adjacency list record.
  typedef struct packed {
    logic             valid;
    logic [ENT_W-1:0] head;
    logic [ENT_W-1:0] tail;
  } node_rec_t;

  // Work queue entry of a search.
  typedef struct packed {
    logic [NODE_W-1:0] hops;
    logic [NODE_W-1:0] node;
  } wq_rec_t;

  // Micro-operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE, OP_CLR, OP_ACCEPT, OP_ADD_RD, OP_ADD_WR, OP_VCLR, OP_BINIT,
    OP_QCHK, OP_QRD, OP_NRD, OP_ERD, OP_VRD, OP_ENEXT, OP_BEND, OP_LCHK,
    OP_LRD, OP_LRD2, OP_KCHK, OP_KRD, OP_FIN
  } op_t;

  typedef struct packed {
    op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic in_clear;
    logic in_add;
    logic in_add_ok;
    logic in_compute;
    logic root_bad;
    logic add_second;
    logic q_empty;
    logic node_valid;
    logic edge_in_range;
    logic tail_hit;
    logic first_bfs;
    logic bounds_met;
    logic level_stop;
    logic dd_is_depth;
    logic k_done;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/gdi_ram.sv -----
// ----------------------------------------------------------------------------
// gdi_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gdi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- hdl/gdi_ctrl.sv -----
// ----------------------------------------------------------------------------
// gdi_ctrl
// Controller state machine: sequences clears, edge appends and BFS sweeps.
// ----------------------------------------------------------------------------
`default_nettype none

module gdi_ctrl import gdi_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t st,
  output ctl_cmd_t      cmd
);

  typedef enum logic [18:0] {
    S_CLR   = 19'd1 << 0,
    S_IDLE  = 19'd1 << 1,
    S_ADDRD = 19'd1 << 2,
    S_ADDWR = 19'd1 << 3,
    S_VCLR  = 19'd1 << 4,
    S_BINIT = 19'd1 << 5,
    S_QCHK  = 19'd1 << 6,
    S_QRD   = 19'd1 << 7,
    S_NRD   = 19'd1 << 8,
    S_ERD   = 19'd1 << 9,
    S_VRD   = 19'd1 << 10,
    S_ENEXT = 19'd1 << 11,
    S_BEND  = 19'd1 << 12,
    S_LCHK  = 19'd1 << 13,
    S_LRD   = 19'd1 << 14,
    S_LRD2  = 19'd1 << 15,
    S_KCHK  = 19'd1 << 16,
    S_KRD   = 19'd1 << 17,
    S_FIN   = 19'd1 << 18
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and the micro-operation of the current state.
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (st.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          if (st.in_clear) state_nxt = S_CLR;
          else if (st.in_add && st.in_add_ok) state_nxt = S_ADDRD;
          else if (st.in_compute && st.root_bad) state_nxt = S_FIN;
          else if (st.in_compute) state_nxt = S_VCLR;
        end
      end
      S_ADDRD: begin
        cmd.op = OP_ADD_RD;
        state_nxt = S_ADDWR;
      end
      S_ADDWR: begin
        cmd.op = OP_ADD_WR;
        state_nxt = st.add_second ? S_IDLE : S_ADDRD;
      end
      S_VCLR: begin
        cmd.op = OP_VCLR;
        if (st.sweep_last) state_nxt = S_BINIT;
      end
      S_BINIT: begin
        cmd.op = OP_BINIT;
        state_nxt = S_QCHK;
      end
      S_QCHK: begin
        cmd.op = OP_QCHK;
        state_nxt = st.q_empty ? S_BEND : S_QRD;
      end
      S_QRD: begin
        cmd.op = OP_QRD;
        state_nxt = S_NRD;
      end
      S_NRD: begin
        cmd.op = OP_NRD;
        state_nxt = st.node_valid ? S_ERD : S_QCHK;
      end
      S_ERD: begin
        cmd.op = OP_ERD;
        state_nxt = st.edge_in_range ? S_VRD : S_ENEXT;
      end
      S_VRD: begin
        cmd.op = OP_VRD;
        state_nxt = S_ENEXT;
      end
      S_ENEXT: begin
        cmd.op = OP_ENEXT;
        state_nxt = st.tail_hit ? S_QCHK : S_ERD;
      end
      S_BEND: begin
        cmd.op = OP_BEND;
        if (st.first_bfs) state_nxt = S_LCHK;
        else if (st.bounds_met) state_nxt = S_FIN;
        else state_nxt = S_KCHK;
      end
      S_LCHK: begin
        cmd.op = OP_LCHK;
        state_nxt = st.level_stop ? S_FIN : S_LRD;
      end
      S_LRD: begin
        cmd.op = OP_LRD;
        state_nxt = st.dd_is_depth ? S_KCHK : S_LRD2;
      end
      S_LRD2: begin
        cmd.op = OP_LRD2;
        state_nxt = S_KCHK;
      end
      S_KCHK: begin
        cmd.op = OP_KCHK;
        state_nxt = st.k_done ? S_LCHK : S_KRD;
      end
      S_KRD: begin
        cmd.op = OP_KRD;
        state_nxt = S_VCLR;
      end
      S_FIN: begin
        cmd.op = OP_FIN;
        if (!st.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  // State register; reset starts with a clearing pass over the node table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/gdi_dp.sv -----
// ----------------------------------------------------------------------------
// gdi_dp
// Datapath: graph store, search queues, level table, bounds and result.
// ----------------------------------------------------------------------------
`default_nettype none

module gdi_dp import gdi_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ctl_cmd_t          cmd,
  output dp_stat_t               st,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [NODE_W-1:0] in_edge_from,
  input  wire logic [NODE_W-1:0] in_edge_to,
  input  wire logic [NODE_W-1:0] in_root_node,
  input  wire logic              cfg_valid,
  input  wire logic [CNT_W-1:0]  cfg_node_count,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [NODE_W-1:0]      out_diameter,
  output logic [CNT_W-1:0]       out_bfs_runs,
  output logic [1:0]             out_status
);

  // Control registers.
  logic [CNT_W-1:0]  node_count_r;
  logic [ECNT_W-1:0] cnt_r;
  logic              dropped_r, side_r, first_r, bad_r, dd_neg_r, out_valid_r;
  logic [NODE_W-1:0] sweep_r;
  // Payload registers.
  logic [NODE_W-1:0] a_r, b_r, src_r, du_r, v_r, ecc_r, maxd_r, depth_r;
  logic [NODE_W-1:0] lb_r, dd_r, out_diam_r;
  logic [CNT_W-1:0]  rd_r, wr_r, reached_r, runs_r, k_r, kend_r, out_runs_r;
  logic [ENT_W-1:0]  e_r, tail_r, nxt_r;
  logic [UB_W-1:0]   ub_r;
  logic [1:0]        out_status_r;

  // RAM ports.
  logic                node_we, vis_we, wq_we, lvl_we, ls_we, adj_we, nxt_we;
  logic [NODE_W-1:0]   node_wa, node_ra, vis_wa, vis_ra, wq_wa, wq_ra;
  logic [NODE_W-1:0]   lvl_wa, lvl_ra, ls_wa, ls_ra, lvl_wd, ls_wd, ls_rd, lvl_rd;
  node_rec_t           node_wd, node_rd;
  logic                vis_wd, vis_rd;
  wq_rec_t             wq_wd, wq_rd;
  logic [ENT_W-1:0]    adj_wa, adj_ra, nxt_wa, nxt_wd, nxt_rd;
  logic [NODE_W-1:0]   adj_wd, adj_rd;

  // Derived values.
  logic [CNT_W-1:0]  n_eff;
  logic [NODE_W-1:0] x_node, y_node, new_d, lb_n;
  logic [UB_W-1:0]   two_e, ub_n, half_ub;
  logic [ECNT_W:0]   cnt_plus2;

  assign n_eff     = (node_count_r > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_r;
  assign x_node    = side_r ? b_r : a_r;
  assign y_node    = side_r ? a_r : b_r;
  assign new_d     = du_r + NODE_W'(1);
  assign two_e     = {1'b0, ecc_r, 1'b0};
  assign lb_n      = (ecc_r > lb_r) ? ecc_r : lb_r;
  assign ub_n      = (two_e < ub_r) ? two_e : ub_r;
  assign half_ub   = (ub_r + UB_W'(1)) >> 1;
  assign cnt_plus2 = {1'b0, cnt_r} + (ECNT_W+1)'(2);

  // Status toward the controller.
  always_comb begin
    st.sweep_last    = &sweep_r;
    st.in_clear      = (in_cmd == CMD_CLEAR);
    st.in_add        = (in_cmd == CMD_ADD);
    st.in_add_ok     = ({1'b0, in_edge_from} < n_eff) && ({1'b0, in_edge_to} < n_eff)
                       && (cnt_plus2 <= (ECNT_W+1)'(ENTRIES));
    st.in_compute    = (in_cmd == CMD_COMPUTE);
    st.root_bad      = ({1'b0, in_root_node} >= n_eff);
    st.add_second    = side_r;
    st.q_empty       = (rd_r == wr_r);
    st.node_valid    = node_rd.valid;
    st.edge_in_range = ({1'b0, adj_rd} < n_eff);
    st.tail_hit      = (e_r == tail_r);
    st.first_bfs     = first_r;
    st.bounds_met    = ({2'b00, lb_n} == ub_n);
    st.level_stop    = dd_neg_r || ({2'b00, dd_r} < half_ub);
    st.dd_is_depth   = (dd_r == depth_r);
    st.k_done        = (k_r >= kend_r);
    st.out_busy      = out_valid_r && !out_ready;
  end

  // Memory addressing per micro-operation.
  always_comb begin
    node_we = 1'b0; node_wa = sweep_r; node_wd = '0; node_ra = x_node;
    adj_we  = 1'b0; adj_wa  = cnt_r[ENT_W-1:0]; adj_wd = y_node; adj_ra = nxt_r;
    nxt_we  = 1'b0; nxt_wa  = node_rd.tail; nxt_wd = cnt_r[ENT_W-1:0];
    vis_we  = 1'b0; vis_wa  = sweep_r; vis_wd = 1'b0; vis_ra = adj_rd;
    wq_we   = 1'b0; wq_wa   = wr_r[NODE_W-1:0]; wq_ra = rd_r[NODE_W-1:0];
    wq_wd   = '{hops: new_d, node: v_r};
    lvl_we  = 1'b0; lvl_wa  = wr_r[NODE_W-1:0]; lvl_wd = v_r; lvl_ra = k_r[NODE_W-1:0];
    ls_we   = 1'b0; ls_wa   = new_d; ls_wd = wr_r[NODE_W-1:0]; ls_ra = dd_r;
    case (cmd.op)
      OP_CLR: node_we = 1'b1;
      OP_ADD_WR: begin
        adj_we  = 1'b1;
        nxt_we  = node_rd.valid;
        node_we = 1'b1;
        node_wa = x_node;
        node_wd = '{valid: 1'b1,
                    head: node_rd.valid ? node_rd.head : cnt_r[ENT_W-1:0],
                    tail: cnt_r[ENT_W-1:0]};
      end
      OP_VCLR: vis_we = 1'b1;
      OP_BINIT: begin
        vis_we = 1'b1; vis_wa = src_r; vis_wd = 1'b1;
        wq_we  = 1'b1; wq_wa = '0; wq_wd = '{hops: '0, node: src_r};
        lvl_we = first_r; lvl_wa = '0; lvl_wd = src_r;
        ls_we  = first_r; ls_wa = '0; ls_wd = '0;
      end
      OP_QRD: node_ra = wq_rd.node;
      OP_NRD: adj_ra = node_rd.head;
      OP_VRD: begin
        vis_we = !vis_rd; vis_wa = v_r; vis_wd = 1'b1;
        wq_we  = !vis_rd;
        lvl_we = !vis_rd && first_r;
        ls_we  = !vis_rd && first_r && (new_d > maxd_r);
      end
      OP_LRD: ls_ra = dd_r + NODE_W'(1);
      default: ;
    endcase
  end

  // Memories.
  gdi_ram #(.WIDTH($bits(node_rec_t)), .DEPTH(MAX_NODES)) u_node_ram (
    .clk, .wr_en(node_we), .wr_addr(node_wa), .wr_data(node_wd),
    .rd_addr(node_ra), .rd_data(node_rd));
  gdi_ram #(.WIDTH(NODE_W), .DEPTH(ENTRIES)) u_adj_ram (
    .clk, .wr_en(adj_we), .wr_addr(adj_wa), .wr_data(adj_wd),
    .rd_addr(adj_ra), .rd_data(adj_rd));
  gdi_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_nxt_ram (
    .clk, .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
    .rd_addr(adj_ra), .rd_data(nxt_rd));
  gdi_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_vis_ram (
    .clk, .wr_en(vis_we), .wr_addr(vis_wa), .wr_data(vis_wd),
    .rd_addr(vis_ra), .rd_data(vis_rd));
  gdi_ram #(.WIDTH($bits(wq_rec_t)), .DEPTH(MAX_NODES)) u_wq_ram (
    .clk, .wr_en(wq_we), .wr_addr(wq_wa), .wr_data(wq_wd),
    .rd_addr(wq_ra), .rd_data(wq_rd));
  gdi_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_lvl_ram (
    .clk, .wr_en(lvl_we), .wr_addr(lvl_wa), .wr_data(lvl_wd),
    .rd_addr(lvl_ra), .rd_data(lvl_rd));
  gdi_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_ls_ram (
    .clk, .wr_en(ls_we), .wr_addr(ls_wa), .wr_data(ls_wd),
    .rd_addr(ls_ra), .rd_data(ls_rd));

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CNT_W'(MAX_NODES);
      cnt_r        <= '0;
      dropped_r    <= 1'b0;
      sweep_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) node_count_r <= cfg_node_count;
      // A new result may replace one that leaves in the same cycle.
      if (cmd.op == OP_FIN && !st.out_busy) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_CLR, OP_VCLR: sweep_r <= sweep_r + NODE_W'(1);
        OP_ACCEPT: begin
          sweep_r <= '0;
          if (st.in_clear) begin
            cnt_r     <= '0;
            dropped_r <= 1'b0;
          end else if (st.in_add && !st.in_add_ok) begin
            dropped_r <= 1'b1;
          end
        end
        OP_ADD_WR: cnt_r <= cnt_r + ECNT_W'(1);
        default: ;
      endcase
    end
  end

  // Search, bounds and result registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        a_r     <= in_edge_from;
        b_r     <= in_edge_to;
        src_r   <= in_root_node;
        side_r  <= 1'b0;
        first_r <= 1'b1;
        bad_r   <= st.root_bad;
        lb_r    <= '0;
        runs_r  <= '0;
      end
      OP_ADD_WR: side_r <= 1'b1;
      OP_BINIT: begin
        rd_r   <= '0;
        wr_r   <= CNT_W'(1);
        ecc_r  <= '0;
        maxd_r <= '0;
      end
      OP_QCHK: if (!st.q_empty) rd_r <= rd_r + CNT_W'(1);
      OP_QRD: begin
        du_r <= wq_rd.hops;
      end
      OP_NRD: begin
        e_r    <= node_rd.head;
        tail_r <= node_rd.tail;
      end
      OP_ERD: begin
        v_r   <= adj_rd;
        nxt_r <= nxt_rd;
      end
      OP_VRD: begin
        if (!vis_rd) begin
          wr_r <= wr_r + CNT_W'(1);
          if (new_d > ecc_r) ecc_r <= new_d;
          if (first_r && new_d > maxd_r) maxd_r <= new_d;
        end
      end
      OP_ENEXT: if (!st.tail_hit) e_r <= nxt_r;
      OP_BEND: begin
        if (first_r) begin
          first_r   <= 1'b0;
          depth_r   <= ecc_r;
          lb_r      <= ecc_r;
          ub_r      <= two_e;
          runs_r    <= CNT_W'(1);
          dd_r      <= ecc_r;
          dd_neg_r  <= 1'b0;
          reached_r <= wr_r;
        end else begin
          lb_r   <= lb_n;
          ub_r   <= ub_n;
          runs_r <= runs_r + CNT_W'(1);
          k_r    <= k_r + CNT_W'(1);
        end
      end
      OP_LRD: begin
        k_r <= {1'b0, ls_rd};
        if (st.dd_is_depth) kend_r <= reached_r;
      end
      OP_LRD2: kend_r <= {1'b0, ls_rd};
      OP_KCHK: begin
        if (st.k_done) begin
          if (dd_r == '0) dd_neg_r <= 1'b1;
          else dd_r <= dd_r - NODE_W'(1);
        end
      end
      OP_KRD: src_r <= lvl_rd;
      OP_FIN: begin
        if (!st.out_busy) begin
          out_diam_r   <= lb_r;
          out_runs_r   <= runs_r;
          out_status_r <= bad_r ? STATUS_BADROOT :
                          (dropped_r ? STATUS_DROPPED : STATUS_OK);
        end
      end
      default: ;
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_diameter = out_diam_r;
  assign out_bfs_runs = out_runs_r;
  assign out_status   = out_status_r;

  // The edge store never fills past its entry count.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ECNT_W'(ENTRIES))
    else $error("edge store count overflow");

  // The queue read pointer never passes the write pointer.
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_QCHK) |-> (rd_r <= wr_r))
    else $error("queue read passed write");

  // The lower bound never exceeds the upper bound while levels are walked.
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_LCHK) |-> ({2'b00, lb_r} <= ub_r))
    else $error("diameter bounds crossed");

endmodule

`default_nettype wire

// ----- hdl/graph_diameter_ifub.sv -----
// ----------------------------------------------------------------------------
// graph_diameter_ifub
// Graph diameter by iFUB over an on-chip adjacency store.
//
//   Channel | Direction | Ports
//   --------+-----------+--------------------------------------------------
//   in      | input     | in_valid/in_ready, cmd, edge_from, edge_to, root
//   out     | output    | out_valid/out_ready, diameter, bfs_runs, status
//   cfg     | input     | cfg_valid/cfg_ready, cfg_node_count
//
// An add transfer runs a read and a write state for each of its two entries;
// clear and reset take a pass over the node table, during which no input
// transfer is taken. Each BFS of a compute starts with a visited-flag sweep,
// then takes its queue, node and adjacency entry steps one at a time, set by the
// single read port of the adjacency memories; level walks add level-table reads.
// A finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_diameter_ifub import gdi_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [NODE_W-1:0] in_edge_from,
  input  wire logic [NODE_W-1:0] in_edge_to,
  input  wire logic [NODE_W-1:0] in_root_node,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [NODE_W-1:0]      out_diameter,
  output logic [CNT_W-1:0]       out_bfs_runs,
  output logic [1:0]             out_status,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CNT_W-1:0]  cfg_node_count
);

  ctl_cmd_t cmd;
  dp_stat_t st;

  // The register write is always taken.
  assign cfg_ready = 1'b1;

  gdi_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .st, .cmd);

  gdi_dp u_dp (
    .clk, .rst_n, .cmd, .st, .in_cmd, .in_edge_from, .in_edge_to, .in_root_node,
    .cfg_valid, .cfg_node_count, .out_valid, .out_ready, .out_diameter,
    .out_bfs_runs, .out_status);

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for graph_diameter_ifub. Builds graphs with clear and
// add transfers, runs diameter computes on them, and compares each result
// against an in-bench iFUB predictor under random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import gdi_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_LIMIT     = 1000000;
  localparam int HOLD_CYCLES    = 150000;
  localparam int TARGET_ITEMS   = 1950;
  localparam int LONG_LIST_ADDS = 600;

  // Predictor of the diameter engine plus the queue of expected results.
  class diameter_scoreboard;
    typedef struct {
      logic [NODE_W-1:0] diameter;
      logic [CNT_W-1:0]  runs;
      logic [1:0]        status;
    } diam_result_t;

    int unsigned node_count;
    bit          list_ok[MAX_NODES];
    int unsigned head[MAX_NODES];
    int unsigned tail[MAX_NODES];
    int unsigned tgt[ENTRIES];
    int unsigned nxt[ENTRIES];
    int unsigned entries;
    bit          dropped;
    int unsigned hop[MAX_NODES];
    bit          seen[MAX_NODES];
    int unsigned level_nodes[MAX_NODES];
    int unsigned sweep_nodes[MAX_NODES];
    int unsigned level_first[MAX_NODES + 1];
    diam_result_t awaited[$];
    int mismatches;
    int results_seen;
    int computes;
    int adds_dropped;

    function new();
      node_count = MAX_NODES;
      entries = 0;
      dropped = 0;
      mismatches = 0;
      results_seen = 0;
      computes = 0;
      adds_dropped = 0;
      foreach (list_ok[i]) list_ok[i] = 0;
    endfunction

    function void set_node_count(int unsigned v);
      node_count = v & 11'h7ff;
    endfunction

    function int unsigned usable_nodes();
      return (node_count > MAX_NODES) ? MAX_NODES : node_count;
    endfunction

    function void link_entry(int unsigned u, int unsigned v);
      tgt[entries] = v;
      if (list_ok[u]) begin
        nxt[tail[u]] = entries;
      end else begin
        head[u] = entries;
        list_ok[u] = 1;
      end
      tail[u] = entries;
      entries++;
    endfunction

    // FIFO breadth-first search; visit order goes to the level list or the
    // scratch list. Returns the eccentricity of src.
    function int unsigned search(int unsigned src, int unsigned n, bit into_level,
                                 output int unsigned reached);
      int unsigned rd, wr, ecc, u, e, v;
      rd = 0;
      wr = 0;
      ecc = 0;
      foreach (seen[i]) seen[i] = 0;
      seen[src] = 1;
      hop[src] = 0;
      if (into_level) level_nodes[wr] = src; else sweep_nodes[wr] = src;
      wr++;
      while (rd < wr) begin
        u = into_level ? level_nodes[rd] : sweep_nodes[rd];
        rd++;
        if (list_ok[u]) begin
          e = head[u];
          while (1) begin
            v = tgt[e];
            if (v < n && !seen[v] && wr < n) begin
              seen[v] = 1;
              hop[v] = hop[u] + 1;
              if (hop[v] > ecc) ecc = hop[v];
              if (into_level) level_nodes[wr] = v; else sweep_nodes[wr] = v;
              wr++;
            end
            if (e == tail[u]) break;
            e = nxt[e];
          end
        end
      end
      reached = wr;
      return ecc;
    endfunction

    // Notes an accepted input transfer and predicts its result, if any.
    function void note_input(logic [1:0] cmd, int unsigned a, int unsigned b,
                             int unsigned root);
      int unsigned n, reached, dummy, depth, lb, ub, runs, e, k, d;
      int dd;
      bit done;
      diam_result_t res;
      n = usable_nodes();
      if (cmd == CMD_CLEAR) begin
        foreach (list_ok[i]) list_ok[i] = 0;
        entries = 0;
        dropped = 0;
      end else if (cmd == CMD_ADD) begin
        if (a >= n || b >= n || entries + 2 > ENTRIES) begin
          dropped = 1;
          adds_dropped++;
        end else begin
          link_entry(a, b);
          link_entry(b, a);
        end
      end else if (cmd == CMD_COMPUTE) begin
        computes++;
        if (root >= n) begin
          res.diameter = '0;
          res.runs = '0;
          res.status = STATUS_BADROOT;
        end else begin
          depth = search(root, n, 1, reached);
          for (int unsigned i = 0; i < reached; i++) begin
            d = hop[level_nodes[i]];
            if (i == 0 || d != hop[level_nodes[i-1]]) level_first[d] = i;
          end
          level_first[depth + 1] = reached;
          lb = depth;
          ub = 2 * depth;
          runs = 1;
          done = 0;
          for (dd = depth; !done && dd >= int'((ub + 1) / 2); dd--) begin
            for (k = level_first[dd]; k < level_first[dd + 1]; k++) begin
              e = search(level_nodes[k], n, 0, dummy);
              if (e > lb) lb = e;
              if (2 * e < ub) ub = 2 * e;
              runs++;
              if (lb == ub) begin
                done = 1;
                break;
              end
            end
          end
          res.diameter = lb[NODE_W-1:0];
          res.runs = runs[CNT_W-1:0];
          res.status = dropped ? STATUS_DROPPED : STATUS_OK;
        end
        awaited.insert(awaited.size(), res);
      end
    endfunction

    // Compares one accepted result transfer with the oldest expectation.
    function void check_result(logic [NODE_W-1:0] diameter, logic [CNT_W-1:0] runs,
                               logic [1:0] status);
      diam_result_t exp_res;
      results_seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result diameter=%0d runs=%0d status=%0d",
                   diameter, runs, status);
        return;
      end
      exp_res = awaited.pop_front();
      if (diameter !== exp_res.diameter || runs !== exp_res.runs ||
          status !== exp_res.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d exp d=%0d runs=%0d st=%0d, got d=%0d runs=%0d st=%0d",
                   results_seen, exp_res.diameter, exp_res.runs, exp_res.status,
                   diameter, runs, status);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_cmd;
  logic [NODE_W-1:0] in_edge_from;
  logic [NODE_W-1:0] in_edge_to;
  logic [NODE_W-1:0] in_root_node;
  logic              out_valid;
  logic              out_ready;
  logic [NODE_W-1:0] out_diameter;
  logic [CNT_W-1:0]  out_bfs_runs;
  logic [1:0]        out_status;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_node_count;

  diameter_scoreboard sb;
  bit steady_mode;
  bit hold_req;
  int items_sent;
  int idle_cycles = 0;
  int config_writes;

  graph_diameter_ifub uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_edge_from   (in_edge_from),
    .in_edge_to     (in_edge_to),
    .in_root_node   (in_root_node),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_diameter   (out_diameter),
    .out_bfs_runs   (out_bfs_runs),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_node_count (cfg_node_count)
  );

  // Clock generation.
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Monitor: every transfer on the three channels feeds the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_node_count(cfg_node_count);
      if (in_valid && in_ready)
        sb.note_input(in_cmd, in_edge_from, in_edge_to, in_root_node);
      if (out_valid && out_ready) sb.check_result(out_diameter, out_bfs_runs, out_status);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("graph_diameter_ifub test failed");
      $finish;
    end
  end

  // Result receiver with random stalls and one long hold-off on request.
  initial begin
    int r;
    int len;
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 0;
      end else if (steady_mode) begin
        out_ready <= 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ready <= 1;
        end else begin
          len = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 80);
          out_ready <= 0;
          repeat (len - 1) @(posedge clk);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offers one input item and waits for its transfer; valid stays high after.
  task automatic send_item(logic [1:0] cmd, int unsigned a, int unsigned b,
                           int unsigned root);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1;
    in_cmd       <= cmd;
    in_edge_from <= a[NODE_W-1:0];
    in_edge_to   <= b[NODE_W-1:0];
    in_root_node <= root[NODE_W-1:0];
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic offer_edge(int unsigned a, int unsigned b);
    send_item(CMD_ADD, a, b, $urandom_range(0, 1023));
  endtask

  task automatic compute(int unsigned root);
    send_item(CMD_COMPUTE, $urandom_range(0, 1023), $urandom_range(0, 1023), root);
  endtask

  task automatic clear_graph();
    send_item(CMD_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 1023));
  endtask

  // Stops offering and waits until every expected result has arrived.
  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  // Writes node_count once the block has settled after the last transfer.
  task automatic write_node_count(int unsigned v);
    drain();
    repeat (1200) @(posedge clk);
    cfg_valid      <= 1;
    cfg_node_count <= v[CNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    config_writes++;
  endtask

  function automatic int unsigned pick_node(int unsigned n, bit wide);
    if (wide || $urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
    return $urandom_range(0, n - 1);
  endfunction

  // Main sequence.
  initial begin
    int unsigned nc;
    int unsigned span;
    int phase;
    int n_adds;
    bit wide;
    sb = new();
    steady_mode = 0;
    hold_req = 0;
    items_sent = 0;
    config_writes = 0;
    rst_n = 0;
    in_valid = 0;
    in_cmd = CMD_CLEAR;
    in_edge_from = '0;
    in_edge_to = '0;
    in_root_node = '0;
    cfg_valid = 0;
    cfg_node_count = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // Directed: empty graph, field extremes, self loop, unused command.
    compute(0);
    offer_edge(0, 1023);
    offer_edge(1023, 1023);
    offer_edge(5, 3);
    send_item(CMD_UNUSED, 1023, 1023, 1023);
    compute(1023);
    compute(3);

    // Directed: bad endpoint, bad root, status after clear.
    write_node_count(8);
    offer_edge(7, 9);
    offer_edge(0, 7);
    offer_edge(1, 2);
    compute(1023);
    compute(7);
    clear_graph();
    compute(0);

    // Directed: shrinking node_count hides stored neighbours.
    offer_edge(0, 1);
    offer_edge(1, 5);
    offer_edge(5, 6);
    write_node_count(4);
    compute(0);
    write_node_count(0);
    compute(0);
    write_node_count(2047);
    offer_edge(1023, 512);
    compute(1023);
    write_node_count(1);
    compute(0);

    // Random phases of graph building and computes.
    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      phase++;
      steady_mode = ($urandom_range(0, 4) == 0);
      if (phase == 10) begin
        // Long adjacency lists on a tiny graph.
        steady_mode = 1;
        write_node_count(4);
        clear_graph();
        for (int i = 0; i < LONG_LIST_ADDS; i++)
          offer_edge($urandom_range(0, 3), $urandom_range(0, 3));
        compute(0);
        compute(3);
        drain();
        clear_graph();
        continue;
      end
      case ($urandom_range(0, 9))
        0:       nc = $urandom_range(1, 2);
        1:       nc = 1024;
        2:       nc = 2047;
        default: nc = $urandom_range(3, 16);
      endcase
      wide = (nc >= 1024);
      span = wide ? 1024 : nc;
      write_node_count(nc);
      if ($urandom_range(0, 9) < 8) clear_graph();
      n_adds = wide ? $urandom_range(20, 40) : $urandom_range(span / 2 + 1, 2 * span);
      if (phase == 5) hold_req = 1;
      for (int i = 0; i < n_adds; i++) begin
        offer_edge(pick_node(span, wide), pick_node(span, wide));
        if ($urandom_range(0, 29) == 0) send_item(CMD_UNUSED, $urandom_range(0, 1023),
                                                  $urandom_range(0, 1023),
                                                  $urandom_range(0, 1023));
      end
      compute(pick_node(span, wide));
      compute(pick_node(span, wide));
      if (phase == 5) begin
        // Long receiver hold: several computes pile up behind it.
        compute(pick_node(span, wide));
        compute(pick_node(span, wide));
      end
    end

    drain();
    repeat (2000) @(posedge clk);
    $display("Covered %0d input items, %0d computes, %0d dropped edges, %0d config writes.",
             items_sent, sb.computes, sb.adds_dropped, config_writes);
    $display("Checked %0d results with %0d mismatches.", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("graph_diameter_ifub test passed");
    end else begin
      $display("graph_diameter_ifub test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
